// File: rtl/core/gisd_pkg.sv
`default_nettype none
package gisd_pkg;

  localparam int NODES = 64;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = IDX_W + 1;
  localparam int VAL_W = 24;
  localparam int VEL_W = 48;
  localparam int ACC_W = 30;

  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RUN = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [2:0] CFG_NODE_COUNT = 3'd0;
  localparam logic [2:0] CFG_STEPS = 3'd1;
  localparam logic [2:0] CFG_STEP_SIZE = 3'd2;
  localparam logic [2:0] CFG_MOMENTUM = 3'd3;
  localparam logic [2:0] CFG_OVERLAP = 3'd4;
  localparam logic [2:0] CFG_COMPLEMENT = 3'd5;

  localparam logic signed [VAL_W-1:0] HALF_Q16 = 24'sd32768;
  localparam logic signed [VAL_W-1:0] ONE_Q16 = 24'sd65536;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
    logic                    mask;
  } gisd_tok_t;

  typedef struct packed {
    logic                    load;
    logic                    shift;
    logic                    acc_clr;
    logic                    acc_en;
    logic                    chk_en;
    logic [CNT_W-1:0]        n;
    logic                    edge_we;
    logic [IDX_W-1:0]        edge_a;
    logic [IDX_W-1:0]        edge_b;
    logic                    edge_bit;
    logic                    val_we;
    logic                    vel_we;
    logic [IDX_W-1:0]        sel;
    logic signed [VAL_W-1:0] val_data;
    logic signed [VEL_W-1:0] vel_data;
    logic                    best_we;
  } gisd_ctl_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic signed [VEL_W-1:0] vel;
    logic signed [ACC_W-1:0] near;
    logic signed [ACC_W-1:0] far;
    logic                    mask;
    logic                    bad;
    logic                    best;
  } gisd_cell_st_t;

endpackage
`default_nettype wire

// File: rtl/core/gisd_if.sv
`default_nettype none
interface gisd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  node_a;
  logic [5:0]  node_b;
  logic        edge_bit;
  logic signed [23:0] node_value;
  logic        clear_velocity;
  modport source (output valid, mode, node_a, node_b, edge_bit, node_value, clear_velocity,
                  input ready);
  modport sink (input valid, mode, node_a, node_b, edge_bit, node_value, clear_velocity,
                output ready);
endinterface

interface gisd_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] value_out;
  logic        best_bit;
  logic        is_mis;
  logic [6:0]  set_size;
  logic [6:0]  best_size;
  logic        improved;
  modport source (output valid, value_out, best_bit, is_mis, set_size, best_size, improved,
                  input ready);
  modport sink (input valid, value_out, best_bit, is_mis, set_size, best_size, improved,
                output ready);
endinterface

interface gisd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/graph_independent_set_descent.sv
// Maximal independent set search by relaxed momentum descent over a graph of
// up to 64 nodes held in a ring of 64 node cells.
// req carries load, run and read items; rsp returns one result per item; cfg
// writes the six control registers (always ready, write only while idle).
// Edge, write and read items are handled in the idle state; their result sits in the rsp
// register the next cycle and req is ready again once that result transfers
// or in the same cycle it transfers.
// A run item with n active nodes and S steps runs S descent steps (none when
// n or S is zero) before its result: each step rotates all values once
// around the ring so every cell sums its neighbor and non-neighbor mass,
// then one shared update unit with a 16 x 32 partial-product multiplier
// visits the active nodes in turn.
// A final rotation checks the thresholded mask and counts it.
// Only one item is in flight; while rsp is stalled no new item is taken.
// Reset clears adjacency, velocities, the best mask and count and loads the
// default registers; node values are undefined until written.
`default_nettype none
module graph_independent_set_descent (
  input wire logic clk,
  input wire logic rst,
  gisd_req_if.sink   req,
  gisd_rsp_if.source rsp,
  gisd_cfg_if.sink   cfg
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_ACC = 3'd2;
  localparam logic [2:0] ST_UPD = 3'd3;
  localparam logic [2:0] ST_CLOAD = 3'd4;
  localparam logic [2:0] ST_CHK = 3'd5;
  localparam logic [2:0] ST_FIN = 3'd6;

  localparam int N = gisd_pkg::NODES;
  localparam int IW = gisd_pkg::IDX_W;
  localparam int CW = gisd_pkg::CNT_W;

  logic [6:0]  node_count;
  logic [15:0] steps_per_run;
  logic [31:0] step_size;
  logic [15:0] momentum_factor;
  logic [11:0] overlap_weight;
  logic [7:0]  complement_weight;

  logic [2:0]    st;
  logic [IW-1:0] cyc;
  logic [IW-1:0] j;
  logic [CW-1:0] n;
  logic [15:0]   steps_left;
  logic [CW-1:0] count;
  logic [6:0]    best_count;
  logic [IW-1:0] node_a;
  logic          upd_start;

  gisd_pkg::gisd_ctl_t     ctl;
  gisd_pkg::gisd_tok_t     tok [N];
  gisd_pkg::gisd_cell_st_t cs [N];
  logic [N-1:0]            bad_vec;

  logic                           upd_done;
  logic signed [gisd_pkg::VAL_W-1:0] upd_val;
  logic signed [gisd_pkg::VEL_W-1:0] upd_vel;

  logic          acc_in;
  logic          rsp_load;
  logic [CW-1:0] n_run;
  logic          ok;
  logic          improve;

  assign cfg.ready = 1'b1;
  assign req.ready = (st == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign acc_in = req.valid && req.ready;
  assign rsp_load = (acc_in && req.mode != gisd_pkg::MODE_RUN) || (st == ST_FIN);
  assign n_run = (node_count > 7'(N)) ? CW'(N) : CW'(node_count);
  assign ok = ~|bad_vec;
  assign improve = ok && ({1'b0, count} > {1'b0, best_count});

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      gisd_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .cell_id (IW'(g)),
        .ctl     (ctl),
        .tok_in  (tok[(g + 1) % N]),
        .tok     (tok[g]),
        .st      (cs[g])
      );
      assign bad_vec[g] = cs[g].bad;
    end
  endgenerate

  gisd_update u_update (
    .clk               (clk),
    .rst               (rst),
    .start             (upd_start),
    .val               (cs[j].val),
    .vel               (cs[j].vel),
    .near              (cs[j].near),
    .far               (cs[j].far),
    .step_size         (step_size),
    .momentum_factor   (momentum_factor),
    .overlap_weight    (overlap_weight),
    .complement_weight (complement_weight),
    .done              (upd_done),
    .new_val           (upd_val),
    .new_vel           (upd_vel)
  );

  always_comb begin
    ctl = '0;
    ctl.n = n;
    ctl.load = (st == ST_LOAD) || (st == ST_CLOAD);
    ctl.acc_clr = ctl.load;
    ctl.shift = (st == ST_ACC) || (st == ST_CHK);
    ctl.acc_en = (st == ST_ACC);
    ctl.chk_en = (st == ST_CHK);
    ctl.best_we = (st == ST_FIN) && improve;
    ctl.edge_a = req.node_a;
    ctl.edge_b = req.node_b;
    ctl.edge_bit = req.edge_bit;
    ctl.edge_we = acc_in && req.mode == gisd_pkg::MODE_EDGE && req.node_a != req.node_b;
    if (st == ST_UPD) begin
      ctl.sel = j;
      ctl.val_data = upd_val;
      ctl.vel_data = upd_vel;
      ctl.val_we = upd_done;
      ctl.vel_we = upd_done;
    end else begin
      ctl.sel = req.node_a;
      ctl.val_data = req.node_value;
      ctl.vel_data = '0;
      ctl.val_we = acc_in && req.mode == gisd_pkg::MODE_WRITE;
      ctl.vel_we = ctl.val_we && req.clear_velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
      steps_per_run <= 16'd500;
      step_size <= 32'd2147484;
      momentum_factor <= 16'd58982;
      overlap_weight <= 12'd500;
      complement_weight <= 8'd5;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        gisd_pkg::CFG_NODE_COUNT: node_count <= cfg.data[6:0];
        gisd_pkg::CFG_STEPS: steps_per_run <= cfg.data[15:0];
        gisd_pkg::CFG_STEP_SIZE: step_size <= cfg.data;
        gisd_pkg::CFG_MOMENTUM: momentum_factor <= cfg.data[15:0];
        gisd_pkg::CFG_OVERLAP: overlap_weight <= cfg.data[11:0];
        gisd_pkg::CFG_COMPLEMENT: complement_weight <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      rsp.valid <= 1'b0;
      best_count <= '0;
      upd_start <= 1'b0;
      n <= '0;
    end else begin
      upd_start <= 1'b0;
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (acc_in) begin
            node_a <= req.node_a;
            if (req.mode == gisd_pkg::MODE_RUN) begin
              n <= n_run;
              steps_left <= steps_per_run;
              st <= (steps_per_run == 16'd0 || n_run == '0) ? ST_CLOAD : ST_LOAD;
            end else begin
              rsp.valid <= 1'b1;
              rsp.value_out <= (req.mode == gisd_pkg::MODE_WRITE) ? req.node_value
                                                                   : cs[req.node_a].val;
              rsp.best_bit <= cs[req.node_a].best;
              rsp.is_mis <= 1'b0;
              rsp.set_size <= '0;
              rsp.best_size <= best_count;
              rsp.improved <= 1'b0;
            end
          end
        end
        ST_LOAD: begin
          cyc <= '0;
          st <= ST_ACC;
        end
        ST_ACC: begin
          cyc <= cyc + 1'b1;
          if (cyc == IW'(N - 1)) begin
            j <= '0;
            upd_start <= 1'b1;
            st <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (upd_done) begin
            if ({1'b0, j} == n - 1'b1) begin
              steps_left <= steps_left - 16'd1;
              st <= (steps_left == 16'd1) ? ST_CLOAD : ST_LOAD;
            end else begin
              j <= j + 1'b1;
              upd_start <= 1'b1;
            end
          end
        end
        ST_CLOAD: begin
          cyc <= '0;
          count <= '0;
          st <= ST_CHK;
        end
        ST_CHK: begin
          cyc <= cyc + 1'b1;
          count <= count + CW'(tok[0].mask);
          if (cyc == IW'(N - 1)) begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (improve) begin
            best_count <= 7'(count);
          end
          rsp.valid <= 1'b1;
          rsp.value_out <= cs[node_a].val;
          rsp.best_bit <= improve ? cs[node_a].mask : cs[node_a].best;
          rsp.is_mis <= ok;
          rsp.set_size <= 7'(count);
          rsp.best_size <= improve ? 7'(count) : best_count;
          rsp.improved <= improve;
          st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_done_in_upd: assert property (@(posedge clk) disable iff (rst)
    upd_done |-> st == ST_UPD)
    else $error("update unit finished outside the update phase");

  a_best_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> best_count >= $past(best_count))
    else $error("best size decreased");

  a_improved_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.improved |-> rsp.is_mis && rsp.set_size == rsp.best_size)
    else $error("improved result without a valid larger set");

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    st == ST_FIN |=> rsp.valid && st == ST_IDLE)
    else $error("run finished without a result");

endmodule
`default_nettype wire

// File: rtl/core/gisd_cell.sv
`default_nettype none
module gisd_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [gisd_pkg::IDX_W-1:0] cell_id,
  input  wire gisd_pkg::gisd_ctl_t     ctl,
  input  wire gisd_pkg::gisd_tok_t     tok_in,
  output gisd_pkg::gisd_tok_t          tok,
  output gisd_pkg::gisd_cell_st_t      st
);

  logic signed [gisd_pkg::VAL_W-1:0] val;
  logic signed [gisd_pkg::VEL_W-1:0] vel;
  logic [gisd_pkg::NODES-1:0]        adj;
  logic signed [gisd_pkg::ACC_W-1:0] near;
  logic signed [gisd_pkg::ACC_W-1:0] far;
  logic                              hits;
  logic                              best;
  logic                              active;
  logic                              mask;
  logic                              tok_ok;
  logic signed [gisd_pkg::ACC_W-1:0] tok_ext;

  assign active = {1'b0, cell_id} < ctl.n;
  assign mask = active && (val > gisd_pkg::HALF_Q16);
  assign tok_ok = (tok.idx != cell_id) && ({1'b0, tok.idx} < ctl.n);
  assign tok_ext = {{(gisd_pkg::ACC_W-gisd_pkg::VAL_W){tok.val[gisd_pkg::VAL_W-1]}}, tok.val};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tok <= '{val: val, idx: cell_id, mask: mask};
    end else if (ctl.shift) begin
      tok <= tok_in;
    end
    if (ctl.acc_clr) begin
      near <= '0;
      far <= '0;
      hits <= 1'b0;
    end else begin
      if (ctl.acc_en && tok_ok) begin
        if (adj[tok.idx]) begin
          near <= near + tok_ext;
        end else begin
          far <= far + tok_ext;
        end
      end
      if (ctl.chk_en && tok_ok && tok.mask && adj[tok.idx]) begin
        hits <= 1'b1;
      end
    end
    if (ctl.val_we && ctl.sel == cell_id) begin
      val <= ctl.val_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel <= '0;
      adj <= '0;
      best <= 1'b0;
    end else begin
      if (ctl.vel_we && ctl.sel == cell_id) begin
        vel <= ctl.vel_data;
      end
      if (ctl.edge_we && ctl.edge_a == cell_id) begin
        adj[ctl.edge_b] <= ctl.edge_bit;
      end
      if (ctl.edge_we && ctl.edge_b == cell_id) begin
        adj[ctl.edge_a] <= ctl.edge_bit;
      end
      if (ctl.best_we) begin
        best <= mask;
      end
    end
  end

  assign st = '{val: val, vel: vel, near: near, far: far, mask: mask,
                bad: active && (mask ? hits : !hits), best: best};

endmodule
`default_nettype wire

// File: rtl/core/gisd_update.sv
`default_nettype none
module gisd_update (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [gisd_pkg::VAL_W-1:0] val,
  input  wire logic signed [gisd_pkg::VEL_W-1:0] vel,
  input  wire logic signed [gisd_pkg::ACC_W-1:0] near,
  input  wire logic signed [gisd_pkg::ACC_W-1:0] far,
  input  wire logic [31:0]                    step_size,
  input  wire logic [15:0]                    momentum_factor,
  input  wire logic [11:0]                    overlap_weight,
  input  wire logic [7:0]                     complement_weight,
  output logic                                done,
  output logic signed [gisd_pkg::VAL_W-1:0]   new_val,
  output logic signed [gisd_pkg::VEL_W-1:0]   new_vel
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_GRAD = 4'd1;
  localparam logic [3:0] PH_MVEL = 4'd2;
  localparam logic [3:0] PH_T1 = 4'd3;
  localparam logic [3:0] PH_MGRAD = 4'd4;
  localparam logic [3:0] PH_T2 = 4'd5;
  localparam logic [3:0] PH_SUM = 4'd6;
  localparam logic [3:0] PH_VAL = 4'd7;

  localparam logic signed [64:0] VEL_MAX = 65'sd140737488355327;
  localparam logic signed [64:0] VEL_MIN = -65'sd140737488355328;
  localparam logic signed [49:0] DIFF_ONE = 50'sd4294967296;

  logic [3:0]         ph;
  logic [1:0]         k;
  logic signed [42:0] p_near;
  logic signed [38:0] p_far;
  logic signed [43:0] grad;
  logic [47:0]        mag;
  logic [31:0]        fac;
  logic [79:0]        acc;
  logic               neg;
  logic signed [63:0] term1;
  logic signed [63:0] term2;

  logic [15:0]        chunk;
  logic [47:0]        pp;
  logic [79:0]        pp_sh;
  logic signed [63:0] term;
  logic signed [64:0] vsum;
  logic signed [49:0] diff;
  logic signed [47:0] grad_ext;

  always_comb begin
    case (k)
      2'd0: chunk = mag[15:0];
      2'd1: chunk = mag[31:16];
      default: chunk = mag[47:32];
    endcase
    pp = chunk * fac;
    case (k)
      2'd0: pp_sh = {32'b0, pp};
      2'd1: pp_sh = {16'b0, pp, 16'b0};
      default: pp_sh = {pp, 32'b0};
    endcase
    term = neg ? -$signed(acc[79:16]) : $signed(acc[79:16]);
    vsum = {term1[63], term1} + {term2[63], term2};
    diff = {{10{val[gisd_pkg::VAL_W-1]}}, val, 16'h0} - {{2{new_vel[47]}}, new_vel};
    grad_ext = {{4{grad[43]}}, grad};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ph)
        PH_IDLE: begin
          if (start) begin
            ph <= PH_GRAD;
          end
        end
        PH_GRAD: ph <= PH_MVEL;
        PH_MVEL: if (k == 2'd2) ph <= PH_T1;
        PH_T1: ph <= PH_MGRAD;
        PH_MGRAD: if (k == 2'd2) ph <= PH_T2;
        PH_T2: ph <= PH_SUM;
        PH_SUM: ph <= PH_VAL;
        PH_VAL: begin
          ph <= PH_IDLE;
          done <= 1'b1;
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ph)
      PH_IDLE: begin
        p_near <= $signed({1'b0, overlap_weight}) * near;
        p_far <= $signed({1'b0, complement_weight}) * far;
      end
      PH_GRAD: begin
        grad <= {p_near[42], p_near} - {{5{p_far[38]}}, p_far} - 44'sd65536;
        mag <= vel[47] ? 48'(-vel) : 48'(vel);
        neg <= vel[47];
        fac <= {16'b0, momentum_factor};
        acc <= '0;
        k <= 2'd0;
      end
      PH_MVEL, PH_MGRAD: begin
        acc <= acc + pp_sh;
        k <= k + 2'd1;
      end
      PH_T1: begin
        term1 <= term;
        mag <= grad[43] ? 48'(-grad_ext) : 48'(grad_ext);
        neg <= grad[43];
        fac <= step_size;
        acc <= '0;
        k <= 2'd0;
      end
      PH_T2: term2 <= term;
      PH_SUM: begin
        if (vsum > VEL_MAX) begin
          new_vel <= VEL_MAX[47:0];
        end else if (vsum < VEL_MIN) begin
          new_vel <= VEL_MIN[47:0];
        end else begin
          new_vel <= vsum[47:0];
        end
      end
      PH_VAL: begin
        if (diff <= 50'sd0) begin
          new_val <= '0;
        end else if (diff >= DIFF_ONE) begin
          new_val <= gisd_pkg::ONE_Q16;
        end else begin
          new_val <= {8'b0, diff[31:16]};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: tb/sv/gisd_checker.sv
`timescale 1ns / 1ps
module gisd_checker (
  input  logic clk,
  input  logic rst,
  gisd_req_if  req,
  gisd_rsp_if  rsp,
  gisd_cfg_if  cfg,
  output int   fails,
  output int   outstanding
);

  typedef struct {
    logic signed [23:0] value_out;
    bit                 best_bit;
    bit                 is_mis;
    bit [6:0]           set_size;
    bit [6:0]           best_size;
    bit                 improved;
  } gisd_result_t;

  localparam longint VEL_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VEL_BOT = -VEL_TOP - 1;

  gisd_result_t result_q[$];
  bit     adj[gisd_pkg::NODES][gisd_pkg::NODES];
  int     val[gisd_pkg::NODES];
  longint vel[gisd_pkg::NODES];
  bit     best[gisd_pkg::NODES];
  int     best_cnt;
  int     err_cnt;
  int unsigned nc, steps, rate, mom, ov, comp;

  function automatic longint scale16(longint x, longint unsigned f);
    longint unsigned mag, r;
    mag = (x < 0) ? -x : x;
    r = mag * (f >> 16) + ((mag * (f & 64'hFFFF)) >> 16);
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  task automatic descend(int n);
    int nxt[gisd_pkg::NODES];
    longint near, far, grad, v, diff;
    for (int j = 0; j < n; j++) begin
      near = 0;
      far = 0;
      for (int i = 0; i < n; i++) begin
        if (i != j) begin
          if (adj[i][j]) near += val[i];
          else far += val[i];
        end
      end
      grad = -65536 + longint'(ov) * near - longint'(comp) * far;
      v = scale16(vel[j], mom) + scale16(grad, rate);
      if (v > VEL_TOP) v = VEL_TOP;
      if (v < VEL_BOT) v = VEL_BOT;
      vel[j] = v;
      diff = longint'(val[j]) * 65536 - v;
      if (diff <= 0) nxt[j] = 0;
      else if (diff >= 64'sd4294967296) nxt[j] = 65536;
      else nxt[j] = int'(diff / 65536);
    end
    for (int j = 0; j < n; j++) val[j] = nxt[j];
  endtask

  task automatic predict(logic [1:0] mode, int a, int b, bit eb, int nv, bit clr);
    gisd_result_t e;
    bit mask[gisd_pkg::NODES];
    int n, cnt, hits;
    bit ok;
    e.is_mis = 0;
    e.set_size = 0;
    e.improved = 0;
    case (mode)
      gisd_pkg::MODE_EDGE: begin
        if (a != b) begin
          adj[a][b] = eb;
          adj[b][a] = eb;
        end
      end
      gisd_pkg::MODE_WRITE: begin
        val[a] = nv;
        if (clr) vel[a] = 0;
      end
      gisd_pkg::MODE_RUN: begin
        n = (nc > gisd_pkg::NODES) ? gisd_pkg::NODES : nc;
        cnt = 0;
        ok = 1;
        for (int s = 0; s < steps; s++) descend(n);
        for (int j = 0; j < n; j++) begin
          mask[j] = val[j] > 32768;
          cnt += mask[j];
        end
        for (int j = 0; j < n; j++) begin
          hits = 0;
          for (int i = 0; i < n; i++)
            if (i != j && mask[i] && adj[i][j]) hits++;
          if (mask[j] ? hits != 0 : hits == 0) ok = 0;
        end
        e.is_mis = ok;
        e.set_size = 7'(cnt);
        if (ok && cnt > best_cnt) begin
          for (int j = 0; j < gisd_pkg::NODES; j++) best[j] = (j < n) ? mask[j] : 0;
          best_cnt = cnt;
          e.improved = 1;
        end
      end
      default: ;
    endcase
    e.value_out = val[a][23:0];
    e.best_bit = best[a];
    e.best_size = 7'(best_cnt);
    result_q.insert(result_q.size(), e);
  endtask

  task automatic report(string field, longint got, longint want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    gisd_result_t e;
    if (rst) begin
      result_q.delete();
      for (int i = 0; i < gisd_pkg::NODES; i++) begin
        for (int k = 0; k < gisd_pkg::NODES; k++) adj[i][k] = 0;
        val[i] = 0;
        vel[i] = 0;
        best[i] = 0;
      end
      best_cnt = 0;
      err_cnt = 0;
      nc = 64;
      steps = 500;
      rate = 2147484;
      mom = 58982;
      ov = 500;
      comp = 5;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          e = result_q.pop_front();
          if (rsp.value_out !== e.value_out) report("value_out", rsp.value_out, e.value_out);
          if (rsp.best_bit !== e.best_bit) report("best_bit", rsp.best_bit, e.best_bit);
          if (rsp.is_mis !== e.is_mis) report("is_mis", rsp.is_mis, e.is_mis);
          if (rsp.set_size !== e.set_size) report("set_size", rsp.set_size, e.set_size);
          if (rsp.best_size !== e.best_size) report("best_size", rsp.best_size, e.best_size);
          if (rsp.improved !== e.improved) report("improved", rsp.improved, e.improved);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          gisd_pkg::CFG_NODE_COUNT: nc = cfg.data[6:0];
          gisd_pkg::CFG_STEPS:      steps = cfg.data[15:0];
          gisd_pkg::CFG_STEP_SIZE:  rate = cfg.data;
          gisd_pkg::CFG_MOMENTUM:   mom = cfg.data[15:0];
          gisd_pkg::CFG_OVERLAP:    ov = cfg.data[11:0];
          gisd_pkg::CFG_COMPLEMENT: comp = cfg.data[7:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        predict(req.mode, req.node_a, req.node_b, req.edge_bit, int'(req.node_value),
                req.clear_velocity);
    end
    fails <= err_cnt;
    outstanding <= result_q.size();
  end

endmodule

// File: tb/sv/graph_independent_set_descent_tb.sv
`timescale 1ns / 1ps
module graph_independent_set_descent_tb;

  localparam int IDLE_LIMIT = 50000;

  logic clk;
  logic rst;
  int   fails;
  int   outstanding;
  int   idle_cycles;
  int   rcycle;
  int   stall_pct;
  int   burst_left;
  bit   quiet;
  int   items;
  int   cur_nodes;
  bit   adj[gisd_pkg::NODES][gisd_pkg::NODES];

  gisd_req_if req();
  gisd_rsp_if rsp();
  gisd_cfg_if cfg();

  graph_independent_set_descent uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  gisd_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                    .fails(fails), .outstanding(outstanding));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
      rcycle <= 0;
      stall_pct <= 0;
    end else begin
      rcycle <= rcycle + 1;
      if (rcycle % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end
      rsp.ready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("graph_independent_set_descent_tb NOT OK");
      $finish;
    end
  end

  task automatic send(logic [1:0] mode, int a, int b, bit eb, int v, bit clr);
    int gap;
    if (burst_left == 0) begin
      quiet = $urandom_range(0, 3) == 0;
      gap = quiet ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        req.valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    req.valid <= 1;
    req.mode <= mode;
    req.node_a <= 6'(a);
    req.node_b <= 6'(b);
    req.edge_bit <= eb;
    req.node_value <= 24'(v);
    req.clear_velocity <= clr;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    items++;
    if (mode == gisd_pkg::MODE_EDGE && a != b) begin
      adj[a][b] = eb;
      adj[b][a] = eb;
    end
  endtask

  task automatic drain();
    req.valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic configure(int nc, int steps, logic [31:0] rate, int mom, int ov, int comp);
    cfg_write(gisd_pkg::CFG_NODE_COUNT, 32'(nc));
    cfg_write(gisd_pkg::CFG_STEPS, 32'(steps));
    cfg_write(gisd_pkg::CFG_STEP_SIZE, rate);
    cfg_write(gisd_pkg::CFG_MOMENTUM, 32'(mom));
    cfg_write(gisd_pkg::CFG_OVERLAP, 32'(ov));
    cfg_write(gisd_pkg::CFG_COMPLEMENT, 32'(comp));
    cur_nodes = nc;
  endtask

  // write a greedy maximal independent set (sometimes spoiled) and run on it
  task automatic pattern_run();
    bit pat[gisd_pkg::NODES];
    int n, off, j;
    n = cur_nodes;
    off = $urandom_range(0, n - 1);
    for (int i = 0; i < gisd_pkg::NODES; i++) pat[i] = 0;
    for (int k = 0; k < n; k++) begin
      j = (k + off) % n;
      pat[j] = 1;
      for (int i = 0; i < n; i++)
        if (i != j && pat[i] && adj[i][j]) pat[j] = 0;
    end
    if ($urandom_range(0, 4) == 0) begin
      j = $urandom_range(0, n - 1);
      pat[j] = !pat[j];
    end
    for (int i = 0; i < n; i++)
      send(gisd_pkg::MODE_WRITE, i, $urandom_range(0, 63), 0,
           pat[i] ? 65536 - $urandom_range(0, 200) : $urandom_range(0, 200), 1);
    send(gisd_pkg::MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0, 0);
    send(gisd_pkg::MODE_READ, $urandom_range(0, 63), 0, 0, 0, 0);
  endtask

  task automatic random_item();
    int n, a, b, r;
    n = cur_nodes;
    r = $urandom_range(0, 99);
    a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    if (r < 30)
      send(gisd_pkg::MODE_EDGE, a, b, $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
    else if (r < 50)
      send(gisd_pkg::MODE_WRITE, a, b, $urandom_range(0, 1),
           ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536),
           $urandom_range(0, 1));
    else if (r < 65)
      send(gisd_pkg::MODE_RUN, a, b, $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
    else if (r < 80)
      send(gisd_pkg::MODE_READ, a, b, $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
    else pattern_run();
  endtask

  initial begin
    clk = 0;
    rst <= 1;
    req.valid <= 0;
    req.mode <= gisd_pkg::MODE_READ;
    req.node_a <= 0;
    req.node_b <= 0;
    req.edge_bit <= 0;
    req.node_value <= 0;
    req.clear_velocity <= 0;
    cfg.valid <= 0;
    cfg.index <= gisd_pkg::CFG_NODE_COUNT;
    cfg.data <= 0;
    burst_left = 0;
    items = 0;
    for (int i = 0; i < gisd_pkg::NODES; i++)
      for (int k = 0; k < gisd_pkg::NODES; k++) adj[i][k] = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    configure(6, 3, 2147484, 58982, 500, 5);
    for (int i = 0; i < gisd_pkg::NODES; i++)
      send(gisd_pkg::MODE_WRITE, i, 0, 0, $urandom_range(0, 65536), 1);

    send(gisd_pkg::MODE_EDGE, 4, 4, 1, 0, 0);
    send(gisd_pkg::MODE_EDGE, 0, 1, 1, 0, 0);
    send(gisd_pkg::MODE_EDGE, 1, 2, 1, 0, 0);
    send(gisd_pkg::MODE_EDGE, 63, 62, 1, 0, 0);
    send(gisd_pkg::MODE_EDGE, 62, 63, 0, 0, 0);
    send(gisd_pkg::MODE_WRITE, 2, 63, 1, 8388607, 1);
    send(gisd_pkg::MODE_WRITE, 3, 0, 0, -8388608, 0);
    send(gisd_pkg::MODE_WRITE, 0, 0, 0, 65536, 1);
    send(gisd_pkg::MODE_WRITE, 1, 0, 0, 32768, 1);
    send(gisd_pkg::MODE_WRITE, 4, 0, 0, 32769, 0);
    send(gisd_pkg::MODE_WRITE, 5, 0, 0, 0, 1);
    send(gisd_pkg::MODE_READ, 63, 0, 0, 0, 0);
    send(gisd_pkg::MODE_READ, 2, 0, 0, 0, 0);
    send(gisd_pkg::MODE_RUN, 0, 0, 0, 0, 0);
    send(gisd_pkg::MODE_READ, 3, 0, 0, 0, 0);
    send(gisd_pkg::MODE_RUN, 4, 0, 0, 0, 0);
    pattern_run();
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(1, 1, 0, 0, 0, 0);
        1: configure(64, 1, 32'hFFFF_FFFF, 65535, 4095, 255);
        2: configure(8, 2, 0, 0, $urandom_range(0, 4095), $urandom_range(0, 255));
        3: configure($urandom_range(2, 10), $urandom_range(1, 6), $urandom, $urandom_range(0, 65535),
                     $urandom_range(0, 4095), $urandom_range(0, 255));
        4: configure(5, 4, 0, 0, $urandom_range(0, 4095), $urandom_range(0, 255));
        5: configure(6, 3, 2147484, 58982, 500, 5);
        6: configure($urandom_range(2, 10), $urandom_range(1, 6), $urandom, $urandom_range(0, 65535),
                     $urandom_range(0, 4095), $urandom_range(0, 255));
        default: configure(64, 2, $urandom, $urandom_range(0, 65535),
                           $urandom_range(0, 4095), $urandom_range(0, 255));
      endcase
      while (items < 80 + (p + 1) * 85) random_item();
      drain();
    end

    if (fails == 0 && outstanding == 0)
      $display("graph_independent_set_descent_tb OK");
    else
      $display("graph_independent_set_descent_tb NOT OK");
    $finish;
  end

endmodule
